### src/quaternion_to_euler_assert.svh
// assertion macros shared by the quaternion to euler converter
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define QTE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/qte_pkg.sv
// shared types, widths and constants of the quaternion to euler converter
package qte_pkg;

  localparam int COMP_W      = 16;
  localparam int PROD_W      = 32;
  localparam int ARG_W       = 36;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int CW          = 45;
  localparam int Z_W         = 34;
  localparam int NORM_EXP    = 40;
  localparam int SH_W        = 6;
  localparam int MAX_STEPS   = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int THR_W       = 16;

  localparam logic [1:0] POLE_NONE  = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 16'd32702;

  localparam logic signed [Z_W-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 34'sd421657428;

  // atan(2^-i) in q3.28
  localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STEPS] = '{
    34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290,
    34'sd16755422,  34'sd8385879,   34'sd4193963,  34'sd2097109,
    34'sd1048571,   34'sd524287,    34'sd262144,   34'sd131072,
    34'sd65536,     34'sd32768,     34'sd16384,    34'sd8192,
    34'sd4096,      34'sd2048,      34'sd1024,     34'sd512,
    34'sd256,       34'sd128,       34'sd64,       34'sd32,
    34'sd16,        34'sd8,         34'sd4,        34'sd2,
    34'sd1,         34'sd1,         34'sd0,        34'sd0
  };

  typedef struct packed {
    logic [1:0]              pole;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] yaw_x;
    logic signed [ARG_W-1:0] pitch_y;
    logic signed [ARG_W-1:0] pitch_x;
    logic signed [ARG_W-1:0] roll_y;
  } qte_args_t;

  typedef struct packed {
    qte_args_t        args;
    logic [RAD_W-1:0] rad;
  } qte_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qte_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qte_qstat_t;

endpackage

### src/qte_front.sv
// front pipeline: products, pole classification and cordic argument setup
module qte_front #(
  parameter int QUAT_WIDTH = 16,
  parameter int IN_DW      = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DW-1:0]         in_tdata,
  input  logic [qte_pkg::THR_W-1:0] thr,
  input  qte_pkg::qte_qstat_t      q_stat,
  output logic                     push,
  output qte_pkg::qte_item_t       item
);
  import qte_pkg::*;

  localparam int NF = 6;

  logic [NF-1:0] vf_r;
  logic          en_f;

  logic signed [QUAT_WIDTH-1:0] raw  [4];
  logic signed [COMP_W-1:0]     comp [4];

  for (genvar k = 0; k < 4; k++) begin : g_comp
    assign raw[k] = $signed(in_tdata[k*QUAT_WIDTH +: QUAT_WIDTH]);
    if (QUAT_WIDTH >= COMP_W) begin : g_shr
      assign comp[k] = COMP_W'(raw[k] >>> (QUAT_WIDTH - COMP_W));
    end else begin : g_shl
      assign comp[k] = $signed({raw[k], {(COMP_W - QUAT_WIDTH){1'b0}}});
    end
  end

  logic signed [COMP_W-1:0] w0_r, x0_r, y0_r, z0_r;
  logic signed [PROD_W-1:0] sqw1_r, sqx1_r, sqy1_r, sqz1_r;
  logic signed [PROD_W-1:0] xy1_r, zw1_r, yw1_r, xz1_r, xw1_r, yz1_r;
  logic signed [COMP_W-1:0] x1_r, w1_r, x2_r, w2_r, x3_r, w3_r, x4_r, w4_r;
  logic signed [Z_W-1:0]    unit2_r, test2_r, test3_r, test4_r;
  logic signed [ARG_W-1:0]  yy2_r, yx2_r, py2_r, px2_r;
  logic signed [ARG_W-1:0]  yy3_r, yx3_r, py3_r, px3_r;
  logic signed [ARG_W-1:0]  yy4_r, yx4_r, py4_r, px4_r;
  logic signed [49:0]       lhs3_r, rhs3_r;
  logic [33:0]              a3_r, b3_r;
  logic [33:0]              at2, two_at2;
  logic [1:0]               pole4_r;
  logic [34:0]              pphh4_r;
  logic [32:0]              pphl4_r;
  logic [33:0]              pplh4_r;
  logic [31:0]              ppll4_r;
  logic [65:0]              rad_sum;
  qte_item_t                item5_r;

  assign en_f      = !vf_r[NF-1] || !q_stat.full;
  assign in_tready = en_f;
  assign push      = vf_r[NF-1] && !q_stat.full;
  assign item      = item5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else if (en_f) begin
      vf_r <= {vf_r[NF-2:0], in_tvalid};
    end
  end

  always_comb begin
    at2     = test2_r[Z_W-1] ? 34'(-test2_r) : 34'(test2_r);
    two_at2 = at2 << 1;
    rad_sum = (66'(pphh4_r) << 32) + (66'(pphl4_r) << 16) + (66'(pplh4_r) << 16)
            + 66'(ppll4_r);
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      w0_r <= comp[0];
      x0_r <= comp[1];
      y0_r <= comp[2];
      z0_r <= comp[3];

      sqw1_r <= w0_r * w0_r;
      sqx1_r <= x0_r * x0_r;
      sqy1_r <= y0_r * y0_r;
      sqz1_r <= z0_r * z0_r;
      xy1_r  <= x0_r * y0_r;
      zw1_r  <= z0_r * w0_r;
      yw1_r  <= y0_r * w0_r;
      xz1_r  <= x0_r * z0_r;
      xw1_r  <= x0_r * w0_r;
      yz1_r  <= y0_r * z0_r;
      x1_r   <= x0_r;
      w1_r   <= w0_r;

      unit2_r <= Z_W'(sqw1_r) + Z_W'(sqx1_r) + Z_W'(sqy1_r) + Z_W'(sqz1_r);
      test2_r <= Z_W'(xy1_r) + Z_W'(zw1_r);
      yy2_r   <= (ARG_W'(yw1_r) - ARG_W'(xz1_r)) <<< 1;
      yx2_r   <= ARG_W'(sqx1_r) - ARG_W'(sqy1_r) - ARG_W'(sqz1_r) + ARG_W'(sqw1_r);
      py2_r   <= (ARG_W'(xw1_r) - ARG_W'(yz1_r)) <<< 1;
      px2_r   <= ARG_W'(sqy1_r) - ARG_W'(sqx1_r) - ARG_W'(sqz1_r) + ARG_W'(sqw1_r);
      x2_r    <= x1_r;
      w2_r    <= w1_r;

      lhs3_r  <= 50'(test2_r) <<< 16;
      rhs3_r  <= $signed(50'($unsigned(unit2_r)) * 50'(thr));
      a3_r    <= $unsigned(unit2_r) - two_at2;
      b3_r    <= $unsigned(unit2_r) + two_at2;
      test3_r <= test2_r;
      yy3_r   <= yy2_r;
      yx3_r   <= yx2_r;
      py3_r   <= py2_r;
      px3_r   <= px2_r;
      x3_r    <= x2_r;
      w3_r    <= w2_r;

      priority if (lhs3_r > rhs3_r) begin
        pole4_r <= POLE_NORTH;
      end else if (lhs3_r < -rhs3_r) begin
        pole4_r <= POLE_SOUTH;
      end else begin
        pole4_r <= POLE_NONE;
      end
      pphh4_r <= 35'(a3_r[32:16]) * 35'(b3_r[33:16]);
      pphl4_r <= 33'(a3_r[32:16]) * 33'(b3_r[15:0]);
      pplh4_r <= 34'(a3_r[15:0]) * 34'(b3_r[33:16]);
      ppll4_r <= 32'(a3_r[15:0]) * 32'(b3_r[15:0]);
      test4_r <= test3_r;
      yy4_r   <= yy3_r;
      yx4_r   <= yx3_r;
      py4_r   <= py3_r;
      px4_r   <= px3_r;
      x4_r    <= x3_r;
      w4_r    <= w3_r;

      item5_r.args.pole    <= pole4_r;
      item5_r.args.pitch_y <= py4_r;
      item5_r.args.pitch_x <= px4_r;
      item5_r.args.roll_y  <= ARG_W'(test4_r) <<< 1;
      item5_r.rad          <= rad_sum[RAD_W-1:0];
      if (pole4_r == POLE_NONE) begin
        item5_r.args.yaw_y <= yy4_r;
        item5_r.args.yaw_x <= yx4_r;
      end else begin
        item5_r.args.yaw_y <= ARG_W'(x4_r);
        item5_r.args.yaw_x <= ARG_W'(w4_r);
      end
    end
  end

endmodule

### src/qte_queue.sv
// short queue between the front and back pipelines
`include "quaternion_to_euler_assert.svh"

module qte_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  qte_pkg::qte_qctl_t  ctl,
  input  qte_pkg::qte_item_t  wr_item,
  output qte_pkg::qte_item_t  rd_item,
  output qte_pkg::qte_qstat_t stat
);
  import qte_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qte_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;
  assign rd_item    = mem_r[rp_r];

  always_comb begin
    unique case ({ctl.push, ctl.pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (ctl.push) wp_r <= wp_r + PTR_W'(1);
      if (ctl.pop)  rp_r <= rp_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  `QTE_ASSERT_IMPL(a_no_overflow, ctl.push, !stat.full, "transfer into full queue")
  `QTE_ASSERT_IMPL(a_no_underflow, ctl.pop, !stat.empty, "pop from empty queue")
  `QTE_ASSERT_NEXT(a_count_up, ctl.push && !ctl.pop, count_r == $past(count_r) + CNT_W'(1), "queue count lost a transfer")

endmodule

### src/qte_isqrt.sv
// pipelined floor square root, one result bit per stage
module qte_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qte_pkg::RAD_W-1:0]  rad,
  output logic [qte_pkg::ROOT_W-1:0] root
);
  import qte_pkg::*;

  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_s;
    logic [ROOT_W-1:0] root_s;
    logic [RAD_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_s  = rad;
      assign root_s = '0;
    end else begin : g_next
      assign rem_s  = rem_r[k-1];
      assign root_s = root_r[k-1];
    end

    assign trial = ((RAD_W+2)'(root_s) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
    assign ge    = (RAD_W+2)'(rem_s) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? RAD_W'((RAD_W+2)'(rem_s) - trial) : rem_s;
        root_r[k] <= ge ? (root_s | (ROOT_W'(1) << B)) : root_s;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

### src/qte_cordic.sv
// pipelined cordic vectoring unit computing atan2(y, x) in q3.28
module qte_cordic #(
  parameter int STEPS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [qte_pkg::ARG_W-1:0] y_in,
  input  logic signed [qte_pkg::ARG_W-1:0] x_in,
  output logic signed [qte_pkg::Z_W-1:0]   z_out
);
  import qte_pkg::*;

  logic signed [ARG_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [Z_W-1:0]   z0_r, z1_r, z2_r;
  logic                    zero0_r, zero1_r, zero2_r;
  logic signed [CW-1:0]    x2_r, y2_r;
  logic [SH_W-1:0]         s1_r;
  logic [ARG_W-1:0]        ay, mag;
  logic [SH_W-1:0]         msb;

  logic signed [CW-1:0]  xs_r [STEPS];
  logic signed [CW-1:0]  ys_r [STEPS];
  logic signed [Z_W-1:0] zs_r [STEPS];
  logic                  zr_r [STEPS];

  always_comb begin
    ay  = y0_r[ARG_W-1] ? $unsigned(-y0_r) : $unsigned(y0_r);
    mag = $unsigned(x0_r) | ay;
    msb = '0;
    for (int k = 0; k < ARG_W; k++) begin
      if (mag[k]) msb = SH_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero0_r <= (x_in == '0) && (y_in == '0);
      if (x_in[ARG_W-1]) begin
        x0_r <= -x_in;
        y0_r <= -y_in;
        z0_r <= y_in[ARG_W-1] ? -PI_Q28 : PI_Q28;
      end else begin
        x0_r <= x_in;
        y0_r <= y_in;
        z0_r <= '0;
      end

      x1_r    <= x0_r;
      y1_r    <= y0_r;
      z1_r    <= z0_r;
      zero1_r <= zero0_r;
      s1_r    <= SH_W'(NORM_EXP) - msb;

      x2_r    <= CW'(x1_r) <<< s1_r;
      y2_r    <= CW'(y1_r) <<< s1_r;
      z2_r    <= z1_r;
      zero2_r <= zero1_r;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0]  xi, yi;
    logic signed [Z_W-1:0] zi;
    logic                  zri;

    if (i == 0) begin : g_first
      assign xi  = x2_r;
      assign yi  = y2_r;
      assign zi  = z2_r;
      assign zri = zero2_r;
    end else begin : g_next
      assign xi  = xs_r[i-1];
      assign yi  = ys_r[i-1];
      assign zi  = zs_r[i-1];
      assign zri = zr_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[CW-1]) begin
          xs_r[i] <= xi + (yi >>> i);
          ys_r[i] <= yi - (xi >>> i);
          zs_r[i] <= zi + ATAN_TAB[i];
        end else begin
          xs_r[i] <= xi - (yi >>> i);
          ys_r[i] <= yi + (xi >>> i);
          zs_r[i] <= zi - ATAN_TAB[i];
        end
        zr_r[i] <= zri;
      end
    end
  end

  assign z_out = zr_r[STEPS-1] ? '0 : zs_r[STEPS-1];

endmodule

### src/qte_back.sv
// back pipeline: square root, three cordic units and the output register
module qte_back #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16,
  parameter int OUT_DW       = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  qte_pkg::qte_item_t       q_item,
  input  qte_pkg::qte_qstat_t      q_stat,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DW-1:0]        out_tdata,
  output logic [1:0]               out_tuser
);
  import qte_pkg::*;

  localparam int LC    = CORDIC_STEPS + 3;
  localparam int NB    = ROOT_W + LC + 1;
  localparam int SHIFT = 32 - ANGLE_WIDTH;
  localparam logic signed [Z_W-1:0] RND =
    (SHIFT > 0) ? (Z_W'(1) <<< ((SHIFT > 0) ? SHIFT - 1 : 0)) : '0;
  localparam logic signed [Z_W-1:0] ANG_HI = Z_W'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [Z_W-1:0] ANG_LO = -ANG_HI - Z_W'(1);

  function automatic logic [ANGLE_WIDTH-1:0] to_angle(input logic signed [Z_W-1:0] z);
    logic signed [Z_W-1:0] t;
    t = (z + RND) >>> SHIFT;
    if (t > ANG_HI) t = ANG_HI;
    if (t < ANG_LO) t = ANG_LO;
    return t[ANGLE_WIDTH-1:0];
  endfunction

  logic [NB-1:0]        vb_r;
  logic                 en_b;
  logic [ROOT_W-1:0]    root;
  qte_args_t            d1_r [ROOT_W];
  logic [1:0]           d2_r [LC];
  qte_args_t            a_s;
  logic signed [Z_W-1:0] zy, zp, zr, yaw2;
  logic [ANGLE_WIDTH-1:0] pitch_a, yaw_a, roll_a;
  logic [OUT_DW-1:0]    out_tdata_r;
  logic [1:0]           out_tuser_r;

  assign en_b       = !vb_r[NB-1] || out_tready;
  assign pop        = en_b && !q_stat.empty;
  assign out_tvalid = vb_r[NB-1];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign a_s        = d1_r[ROOT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (en_b) begin
      vb_r <= {vb_r[NB-2:0], pop};
    end
  end

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en_b),
    .rad  (q_item.rad),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en_b) begin
      d1_r[0] <= q_item.args;
      for (int k = 1; k < ROOT_W; k++) d1_r[k] <= d1_r[k-1];
      d2_r[0] <= a_s.pole;
      for (int k = 1; k < LC; k++) d2_r[k] <= d2_r[k-1];
    end
  end

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk (clk), .en (en_b), .y_in (a_s.yaw_y), .x_in (a_s.yaw_x), .z_out (zy)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk (clk), .en (en_b), .y_in (a_s.pitch_y), .x_in (a_s.pitch_x), .z_out (zp)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk (clk), .en (en_b), .y_in (a_s.roll_y), .x_in ($signed(ARG_W'(root))),
    .z_out (zr)
  );

  always_comb begin
    yaw2 = zy <<< 1;
    unique case (d2_r[LC-1])
      POLE_NORTH: begin
        pitch_a = '0;
        yaw_a   = to_angle(yaw2);
        roll_a  = to_angle(HALF_PI_Q28);
      end
      POLE_SOUTH: begin
        pitch_a = '0;
        yaw_a   = to_angle(-yaw2);
        roll_a  = to_angle(-HALF_PI_Q28);
      end
      default: begin
        pitch_a = to_angle(zp);
        yaw_a   = to_angle(zy);
        roll_a  = to_angle(zr);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      out_tdata_r <= OUT_DW'({roll_a, yaw_a, pitch_a});
      out_tuser_r <= d2_r[LC-1];
    end
  end

endmodule

### src/quaternion_to_euler.sv
// quaternion to euler angle converter, top level
// throughput: one quaternion per cycle while out_tready does not stall the output;
// the pipelines and the cordic units are fully unrolled
// the square root pipeline (32 stages) and the cordic step chain set the latency
// reset: rst_n low at a clock edge empties all pipelines and the queue
// and restores the pole threshold to 0.499
module quaternion_to_euler #(
  parameter int QUAT_WIDTH   = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0]  in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] out_tdata,  // pitch_angle, yaw_angle, roll_angle
  output logic [1:0]                         out_tuser,  // pole_case
  input  logic                               cfg_wr_en,
  input  logic [qte_pkg::THR_W-1:0]          cfg_wr_data
);
  import qte_pkg::*;

  localparam int IN_DW  = ((4 * QUAT_WIDTH + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * ANGLE_WIDTH + 7) / 8) * 8;

  logic [THR_W-1:0] thr_r;
  qte_qctl_t        q_ctl;
  qte_qstat_t       q_stat;
  qte_item_t        f_item, q_item;
  logic             push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign q_ctl.push = push;
  assign q_ctl.pop  = pop;

  qte_front #(.QUAT_WIDTH(QUAT_WIDTH), .IN_DW(IN_DW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .thr       (thr_r),
    .q_stat    (q_stat),
    .push      (push),
    .item      (f_item)
  );

  qte_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .wr_item (f_item),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  qte_back #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS),
    .OUT_DW       (OUT_DW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### sim/quaternion_to_euler_test.sv
// self-checking testbench for the quaternion to euler angle converter
`timescale 1ns / 100ps

module quaternion_to_euler_test;
  import qte_pkg::*;

  localparam int STEPS = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [1:0]  pole;
  } euler_t;

  typedef enum int {Q_FULL, Q_SMALL, Q_NORTH, Q_SOUTH, Q_UNIT} quat_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  logic [63:0] pending_quats[$];
  euler_t      angles_due[$];
  longint      atan_steps[STEPS];
  longint      pi_c;
  longint      half_pi_c;
  longint unsigned thr_now;
  int          errors;
  int          results_seen;
  int          send_gap;
  int          recv_gap;
  int          hold_left;
  int          quiet_cycles;
  bit          hold_done;

  quaternion_to_euler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned atan_recip_q60(longint unsigned n);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned k;
    p = (64'd1 << 60) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      if (k[0] == 1'b0) sum = sum + p / (2 * k + 1);
      else sum = sum - p / (2 * k + 1);
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic longint round_q28(longint unsigned v);
    return longint'((v + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint ax;
    longint ay;
    longint m;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? pi_c : -pi_c;
      x = -x;
      y = -y;
    end
    ax = x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    while (m < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_steps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_steps[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] to_q12(longint z);
    z = (z + (64'sd1 <<< 15)) >>> 16;
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    return z[15:0];
  endfunction

  function automatic euler_t convert_quat(logic [63:0] d);
    longint w;
    longint x;
    longint y;
    longint z;
    longint unit;
    longint test;
    longint lhs;
    longint rhs;
    longint pitch;
    longint yaw;
    longint roll;
    longint unsigned at;
    longint unsigned u;
    longint unsigned lo_f;
    longint unsigned rad;
    euler_t r;
    w = longint'($signed(d[15:0]));
    x = longint'($signed(d[31:16]));
    y = longint'($signed(d[47:32]));
    z = longint'($signed(d[63:48]));
    unit = w * w + x * x + y * y + z * z;
    test = x * y + z * w;
    lhs = test * 65536;
    rhs = longint'(thr_now) * unit;
    if (lhs > rhs) begin
      yaw = 2 * vector_angle(x, w);
      roll = half_pi_c;
      pitch = 0;
      r.pole = POLE_NORTH;
    end else if (lhs < -rhs) begin
      yaw = -2 * vector_angle(x, w);
      roll = -half_pi_c;
      pitch = 0;
      r.pole = POLE_SOUTH;
    end else begin
      at = (test < 0) ? -test : test;
      u = unit;
      lo_f = (u >= 2 * at) ? u - 2 * at : 0;
      rad = floor_sqrt(lo_f * (u + 2 * at));
      yaw = vector_angle(2 * (y * w - x * z), x * x - y * y - z * z + w * w);
      roll = vector_angle(2 * test, longint'(rad));
      pitch = vector_angle(2 * (x * w - y * z), -x * x + y * y - z * z + w * w);
      r.pole = POLE_NONE;
    end
    r.pitch = to_q12(pitch);
    r.yaw = to_q12(yaw);
    r.roll = to_q12(roll);
    return r;
  endfunction

  function automatic logic [15:0] jitter(int a);
    return 16'(a + $signed($urandom_range(0, 64)) - 32);
  endfunction

  function automatic logic [63:0] draw_quat(quat_kind_t k);
    int a;
    logic [15:0] c[4];
    a = $urandom_range(1, 16383);
    if ($urandom_range(0, 1)) a = -a;
    case (k)
      Q_FULL: begin
        for (int i = 0; i < 4; i++) c[i] = 16'($urandom);
      end
      Q_SMALL: begin
        for (int i = 0; i < 4; i++) c[i] = 16'($signed($urandom_range(0, 512)) - 256);
      end
      Q_NORTH: begin
        c[0] = jitter(a); c[1] = jitter(a); c[2] = jitter(a); c[3] = jitter(a);
      end
      Q_SOUTH: begin
        c[0] = jitter(a); c[1] = jitter(-a); c[2] = jitter(a); c[3] = jitter(-a);
      end
      default: begin
        c[0] = 16'(a); c[1] = 16'(a); c[2] = 16'(a); c[3] = 16'(a);
      end
    endcase
    return {c[3], c[2], c[1], c[0]};
  endfunction

  task automatic queue_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 4) pending_quats.push_back(draw_quat(Q_FULL));
      else if (k < 5) pending_quats.push_back(draw_quat(Q_SMALL));
      else if (k < 7) pending_quats.push_back(draw_quat(Q_NORTH));
      else if (k < 9) pending_quats.push_back(draw_quat(Q_SOUTH));
      else pending_quats.push_back(draw_quat(Q_UNIT));
    end
  endtask

  task automatic drain;
    wait (pending_quats.size() == 0 && !in_tvalid && angles_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    thr_now = 64'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) angles_due.push_back(convert_quat(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_quats.size() > 0) begin
          in_tdata <= pending_quats.pop_front();
          in_tvalid <= 1'b1;
          send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    euler_t want;
    int gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (angles_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h pole %0d", out_tdata, out_tuser);
        end else begin
          want = angles_due.pop_front();
          if (out_tdata[15:0] !== want.pitch || out_tdata[31:16] !== want.yaw ||
              out_tdata[47:32] !== want.roll || out_tuser !== want.pole) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: pitch %h/%h yaw %h/%h roll %h/%h pole %0d/%0d (exp/act)",
                       want.pitch, out_tdata[15:0], want.yaw, out_tdata[31:16],
                       want.roll, out_tdata[47:32], want.pole, out_tuser);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen == 300) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        recv_gap <= (gap > 0) ? gap - 1 : 0;
        out_tready <= (gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("quaternion_to_euler_test: done, errors");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    results_seen = 0;
    quiet_cycles = 0;
    hold_done = 1'b0;
    thr_now = 64'(THR_RESET);
    atan_steps[0] = round_q28(atan_recip_q60(2) + atan_recip_q60(3));
    for (int i = 1; i < STEPS; i++) atan_steps[i] = round_q28(atan_recip_q60(64'd1 << i));
    pi_c = round_q28(4 * (atan_recip_q60(2) + atan_recip_q60(3)));
    half_pi_c = round_q28(2 * (atan_recip_q60(2) + atan_recip_q60(3)));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero, identity, axis extremes, exact poles
    pending_quats.push_back(64'h0);
    pending_quats.push_back({16'h0000, 16'h0000, 16'h0000, 16'h7fff});
    pending_quats.push_back({16'h0000, 16'h0000, 16'h0000, 16'h8000});
    pending_quats.push_back({16'h0000, 16'h0000, 16'h7fff, 16'h0000});
    pending_quats.push_back({16'h0000, 16'h8000, 16'h0000, 16'h0000});
    pending_quats.push_back({16'h7fff, 16'h0000, 16'h0000, 16'h0000});
    pending_quats.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pending_quats.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    pending_quats.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    pending_quats.push_back({16'h4000, 16'h4000, 16'h4000, 16'h4000});
    pending_quats.push_back({16'hc000, 16'h4000, 16'hc000, 16'h4000});
    pending_quats.push_back({16'h0001, 16'h0001, 16'h0001, 16'h0001});
    pending_quats.push_back({16'hffff, 16'h0000, 16'h0000, 16'h0000});
    pending_quats.push_back({16'h5a82, 16'h0000, 16'h0000, 16'h5a82});
    pending_quats.push_back({16'h0000, 16'h5a82, 16'h0000, 16'ha57e});
    queue_random(500);
    drain();
    write_threshold(16'd0);
    pending_quats.push_back(64'h0);
    queue_random(200);
    drain();
    // magnitude-one ratio stays regular with the largest threshold
    write_threshold(16'hffff);
    pending_quats.push_back({16'h4000, 16'h4000, 16'h4000, 16'h4000});
    pending_quats.push_back({16'hc000, 16'h4000, 16'hc000, 16'h4000});
    pending_quats.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    queue_random(250);
    drain();
    write_threshold(16'h8000);
    pending_quats.push_back({16'h4000, 16'h4000, 16'h4000, 16'h4000});
    queue_random(250);
    drain();
    write_threshold(16'($urandom));
    queue_random(230);
    drain();
    if (errors == 0 && angles_due.size() == 0) begin
      $display("quaternion_to_euler_test: done, clean");
    end else begin
      $display("quaternion_to_euler_test: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/qte_pkg.sv
src/qte_front.sv
src/qte_queue.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/qte_back.sv
src/quaternion_to_euler.sv
sim/quaternion_to_euler_test.sv
